FILE: rtl/core/h264rtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP packetizer package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

   // Length fields and fragment fill counts stay below 2048 for any
   // packet limit up to 1500 bytes.
   localparam int LEN_BITS    = 11;
   localparam int FILL_BITS   = 11;
   localparam int QUEUE_DEPTH = 4;

   localparam int START_CODE_BYTES = 4;
   localparam int MIN_FRAME_BYTES  = 5;
   localparam int RTP_HDR_BYTES    = 12;
   localparam int TCP_HDR_BYTES    = 16;
   localparam int FU_HDR_BYTES     = 2;

   localparam logic [7:0] NRI_MASK      = 8'h60;
   localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
   localparam logic [7:0] FU_A_TYPE     = 8'd28;
   localparam logic [7:0] FU_START_BIT  = 8'h80;
   localparam logic [7:0] FU_END_BIT    = 8'h40;

   // Configuration register indexes.
   localparam logic REG_TRANSPORT_TCP = 1'b0;
   localparam logic REG_SOURCE_ID     = 1'b1;

   // What header, if any, goes out in front of a queued payload byte.
   typedef enum logic [1:0] {
      PKT_NONE,
      PKT_SINGLE,
      PKT_FU
   } pkt_kind_type;

   // One payload byte, with the header fields of the packet when it opens one.
   typedef struct packed {
      logic [7:0]          data;
      logic                pkt_end;
      logic                frame_end;
      pkt_kind_type        kind;
      logic                marker;
      logic [LEN_BITS-1:0] length;
      logic [15:0]         seq;
      logic [31:0]         ts;
      logic [7:0]          fu_ind;
      logic [7:0]          fu_hdr;
   } entry_type;

endpackage

FILE: rtl/core/h264rtp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP packetizer front end
// Tracks the frame position, drops the start code, makes the single/FU-A
// decision and turns each NAL byte into a queue entry with its header fields.
// ----------------------------------------------------------------------------
module h264rtp_front #(
   parameter int TCP_SEGMENT_BYTES = 1460,
   parameter int UDP_PACKET_BYTES  = 1472,
   parameter int FRAME_SIZE_BITS   = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       transport_tcp,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic [FRAME_SIZE_BITS-1:0] req_frame_size,
   input  logic [31:0]                req_timestamp,
   output logic                       push_valid,
   input  logic                       push_ready,
   output h264rtp_pkg::entry_type     push_entry
);

   localparam int SZ = FRAME_SIZE_BITS;
   localparam int LB = h264rtp_pkg::LEN_BITS;
   localparam int FB = h264rtp_pkg::FILL_BITS;
   localparam int TCP_MAX = TCP_SEGMENT_BYTES - h264rtp_pkg::TCP_HDR_BYTES;
   localparam int UDP_MAX = UDP_PACKET_BYTES - h264rtp_pkg::RTP_HDR_BYTES;

   logic [SZ-1:0] pos_ff, pos_in;
   logic [15:0]   seq_ff, seq_in;
   logic [7:0]    nal_ff, nal_in;
   logic [FB-1:0] fill_ff, fill_in;
   logic          frag_ff, frag_in;
   logic [31:0]   ts_ff, ts_in;

   logic [LB-1:0] payload_max;
   logic [FB-1:0] frag_len;
   logic [FB-1:0] fill_next;
   logic [LB-1:0] fu_len;
   logic [SZ-1:0] size_eff;
   logic [SZ:0]   rem;
   logic          last;
   logic          nal_big;
   logic          end_frag;
   logic          emit;
   logic          accept;

   assign payload_max = transport_tcp ? LB'(TCP_MAX) : LB'(UDP_MAX);
   assign frag_len    = transport_tcp ? FB'(TCP_MAX - h264rtp_pkg::FU_HDR_BYTES)
                                      : FB'(UDP_MAX - h264rtp_pkg::FU_HDR_BYTES);

   assign size_eff = (req_frame_size < SZ'(h264rtp_pkg::MIN_FRAME_BYTES)) ?
                     SZ'(h264rtp_pkg::MIN_FRAME_BYTES) : req_frame_size;
   assign last     = ({1'b0, pos_ff} + (SZ+1)'(1)) >= {1'b0, size_eff};
   assign nal_big  = {1'b0, size_eff} >
                     ((SZ+1)'(payload_max) + (SZ+1)'(h264rtp_pkg::START_CODE_BYTES));

   // A negative remainder (size shrunk below the position) counts as large.
   assign rem       = {1'b0, size_eff} - {1'b0, pos_ff};
   assign end_frag  = !rem[SZ] && (rem[SZ-1:0] <= SZ'(frag_len));
   assign fu_len    = end_frag ? rem[LB-1:0] : LB'(frag_len);
   assign fill_next = fill_ff + FB'(1);

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid && emit;

   always_comb begin
      pos_in  = pos_ff;
      seq_in  = seq_ff;
      nal_in  = nal_ff;
      fill_in = fill_ff;
      frag_in = frag_ff;
      ts_in   = ts_ff;
      emit    = 1'b0;

      push_entry           = '0;
      push_entry.data      = req_data_byte;
      push_entry.kind      = h264rtp_pkg::PKT_NONE;
      push_entry.ts        = ts_ff;
      push_entry.pkt_end   = last;
      push_entry.frame_end = last;

      if (pos_ff == '0) begin
         ts_in = req_timestamp;
      end

      if (pos_ff < SZ'(h264rtp_pkg::START_CODE_BYTES)) begin
         emit = 1'b0;
      end else if (pos_ff == SZ'(h264rtp_pkg::START_CODE_BYTES)) begin
         nal_in  = req_data_byte;
         fill_in = '0;
         if (nal_big) begin
            frag_in = 1'b1;
         end else begin
            frag_in           = 1'b0;
            seq_in            = seq_ff + 16'd1;
            emit              = 1'b1;
            push_entry.kind   = h264rtp_pkg::PKT_SINGLE;
            push_entry.length = size_eff[LB-1:0] +
               LB'(h264rtp_pkg::RTP_HDR_BYTES - h264rtp_pkg::START_CODE_BYTES);
         end
      end else if (!frag_ff) begin
         emit = 1'b1;
      end else begin
         emit = 1'b1;
         if (fill_ff == '0) begin
            seq_in            = seq_ff + 16'd1;
            push_entry.kind   = h264rtp_pkg::PKT_FU;
            push_entry.marker = end_frag;
            push_entry.length = fu_len +
               LB'(h264rtp_pkg::RTP_HDR_BYTES + h264rtp_pkg::FU_HDR_BYTES);
            push_entry.fu_ind = (nal_ff & h264rtp_pkg::NRI_MASK) | h264rtp_pkg::FU_A_TYPE;
            push_entry.fu_hdr =
               ((pos_ff == SZ'(h264rtp_pkg::MIN_FRAME_BYTES)) ? h264rtp_pkg::FU_START_BIT
                                                              : 8'h00) |
               (end_frag ? h264rtp_pkg::FU_END_BIT : 8'h00) |
               (nal_ff & h264rtp_pkg::NAL_TYPE_MASK);
         end
         push_entry.pkt_end = last || (fill_next >= frag_len);
         fill_in = push_entry.pkt_end ? '0 : fill_next;
      end

      push_entry.seq = seq_in;

      if (last) begin
         pos_in  = '0;
         fill_in = '0;
         frag_in = 1'b0;
      end else begin
         pos_in = pos_ff + SZ'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         seq_ff  <= '0;
         nal_ff  <= '0;
         fill_ff <= '0;
         frag_ff <= 1'b0;
         ts_ff   <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         seq_ff  <= seq_in;
         nal_ff  <= nal_in;
         fill_ff <= fill_in;
         frag_ff <= frag_in;
         ts_ff   <= ts_in;
      end
   end

endmodule

FILE: rtl/core/h264rtp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP packetizer entry queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module h264rtp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  h264rtp_pkg::entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output h264rtp_pkg::entry_type pop_entry
);

   localparam int DEPTH = h264rtp_pkg::QUEUE_DEPTH;
   localparam int PB    = $clog2(DEPTH);

   h264rtp_pkg::entry_type slot_ff [DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PB:0]   count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = count_ff != (PB+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff + (PB+1)'(do_push) - (PB+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/h264rtp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP packetizer back end
// Walks the head entry of the queue one output byte per cycle while rsp_ready
// allows: interleave prefix, RTP header, FU-A bytes, then the payload byte.
// ----------------------------------------------------------------------------
module h264rtp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   transport_tcp,
   input  logic [31:0]            stream_source_id,
   input  logic                   head_valid,
   output logic                   head_pop,
   input  h264rtp_pkg::entry_type head,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_packet_end,
   output logic                   rsp_frame_end
);

   localparam logic [4:0] STEP_MAGIC   = 5'd0;
   localparam logic [4:0] STEP_CHANNEL = 5'd1;
   localparam logic [4:0] STEP_LEN_HI  = 5'd2;
   localparam logic [4:0] STEP_LEN_LO  = 5'd3;
   localparam logic [4:0] STEP_VERSION = 5'd4;
   localparam logic [4:0] STEP_PTYPE   = 5'd5;
   localparam logic [4:0] STEP_SEQ_HI  = 5'd6;
   localparam logic [4:0] STEP_SEQ_LO  = 5'd7;
   localparam logic [4:0] STEP_TS_3    = 5'd8;
   localparam logic [4:0] STEP_TS_2    = 5'd9;
   localparam logic [4:0] STEP_TS_1    = 5'd10;
   localparam logic [4:0] STEP_TS_0    = 5'd11;
   localparam logic [4:0] STEP_SRC_3   = 5'd12;
   localparam logic [4:0] STEP_SRC_2   = 5'd13;
   localparam logic [4:0] STEP_SRC_1   = 5'd14;
   localparam logic [4:0] STEP_SRC_0   = 5'd15;
   localparam logic [4:0] STEP_FU_IND  = 5'd16;
   localparam logic [4:0] STEP_FU_HDR  = 5'd17;
   localparam logic [4:0] STEP_DATA    = 5'd16;
   localparam logic [4:0] STEP_FU_DATA = 5'd18;

   localparam logic [7:0] MAGIC_BYTE   = 8'h24;
   localparam logic [7:0] CHANNEL_BYTE = 8'h00;
   localparam logic [7:0] VERSION_BYTE = 8'h80;
   localparam logic [6:0] PAYLOAD_TYPE = 7'd96;

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       pkt_end_ff;
   logic       frame_end_ff;
   logic       started_ff;
   logic [4:0] step_ff;

   logic [4:0] start_step;
   logic [4:0] data_step;
   logic [4:0] step;
   logic       at_data;
   logic       load;
   logic       emit;
   logic [7:0] byte_sel;
   logic       is_fu;

   assign is_fu = head.kind == h264rtp_pkg::PKT_FU;

   // Plain payload bytes skip the header; UDP packets skip the interleave prefix.
   always_comb begin
      if (head.kind == h264rtp_pkg::PKT_NONE) begin
         start_step = STEP_DATA;
      end else if (transport_tcp) begin
         start_step = STEP_MAGIC;
      end else begin
         start_step = STEP_VERSION;
      end
   end

   assign data_step = is_fu ? STEP_FU_DATA : STEP_DATA;
   assign step      = started_ff ? step_ff : start_step;
   assign at_data   = step == data_step;
   assign load      = !valid_ff || rsp_ready;
   assign emit      = head_valid && load;
   assign head_pop  = emit && at_data;

   always_comb begin
      case (step)
         STEP_MAGIC:   byte_sel = MAGIC_BYTE;
         STEP_CHANNEL: byte_sel = CHANNEL_BYTE;
         STEP_LEN_HI:  byte_sel = 8'(head.length >> 8);
         STEP_LEN_LO:  byte_sel = head.length[7:0];
         STEP_VERSION: byte_sel = VERSION_BYTE;
         STEP_PTYPE:   byte_sel = {head.marker, PAYLOAD_TYPE};
         STEP_SEQ_HI:  byte_sel = head.seq[15:8];
         STEP_SEQ_LO:  byte_sel = head.seq[7:0];
         STEP_TS_3:    byte_sel = head.ts[31:24];
         STEP_TS_2:    byte_sel = head.ts[23:16];
         STEP_TS_1:    byte_sel = head.ts[15:8];
         STEP_TS_0:    byte_sel = head.ts[7:0];
         STEP_SRC_3:   byte_sel = stream_source_id[31:24];
         STEP_SRC_2:   byte_sel = stream_source_id[23:16];
         STEP_SRC_1:   byte_sel = stream_source_id[15:8];
         STEP_SRC_0:   byte_sel = stream_source_id[7:0];
         STEP_FU_IND:  byte_sel = is_fu ? head.fu_ind : head.data;
         STEP_FU_HDR:  byte_sel = head.fu_hdr;
         STEP_FU_DATA: byte_sel = head.data;
         default:      byte_sel = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         if (load) begin
            valid_ff <= head_valid;
         end
         if (emit) begin
            started_ff <= !at_data;
            step_ff    <= step + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff      <= byte_sel;
         pkt_end_ff   <= at_data && head.pkt_end;
         frame_end_ff <= at_data && head.frame_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_packet_end = pkt_end_ff;
   assign rsp_frame_end  = frame_end_ff;

endmodule

FILE: rtl/core/h264_rtp_packetizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP packetizer
// Turns an Annex B frame (start code plus one NAL unit) into a byte stream of
// RTP packets, single NAL unit or FU-A fragments, with optional TCP framing.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one frame byte per beat, with the frame size and
// timestamp alongside every beat. The rsp_ channel carries one packet byte
// per beat, flagged by rsp_packet_end and rsp_frame_end. The csr_ channel
// writes transport_tcp (index 0) and stream_source_id (index 1); write it
// only while the block has drained, since queued bytes pick up the new
// settings when they leave.
// The back end sends one byte per cycle while entries are queued and the
// receiver takes them. The first payload byte of a packet follows its
// header, 12 bytes in UDP mode and 16 in TCP mode, plus 2 FU-A bytes. Start
// code bytes produce nothing. An item is registered in the queue, then its
// output byte in the output register. A four-entry queue lets the input keep
// running while the back end emits a header or the receiver stalls; when it
// fills, req_ready drops. A stalled rsp beat holds its byte.
// Reset clears the frame position, sequence number and queue, and sets
// transport_tcp to 1 and stream_source_id to 0.
// ----------------------------------------------------------------------------
module h264_rtp_packetizer #(
   parameter int TCP_SEGMENT_BYTES = 1460,
   parameter int UDP_PACKET_BYTES  = 1472,
   parameter int FRAME_SIZE_BITS   = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [31:0]                csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic [FRAME_SIZE_BITS-1:0] req_frame_size,
   input  logic [31:0]                req_timestamp,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_packet_end,
   output logic                       rsp_frame_end
);

   logic        tcp_ff;
   logic [31:0] ssrc_ff;

   logic                   push_valid;
   logic                   push_ready;
   h264rtp_pkg::entry_type push_entry;
   logic                   head_valid;
   logic                   head_pop;
   h264rtp_pkg::entry_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_ff  <= 1'b1;
         ssrc_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            h264rtp_pkg::REG_TRANSPORT_TCP: tcp_ff  <= csr_wdata[0];
            h264rtp_pkg::REG_SOURCE_ID:     ssrc_ff <= csr_wdata;
            default:                        tcp_ff  <= tcp_ff;
         endcase
      end
   end

   h264rtp_front #(
      .TCP_SEGMENT_BYTES (TCP_SEGMENT_BYTES),
      .UDP_PACKET_BYTES  (UDP_PACKET_BYTES),
      .FRAME_SIZE_BITS   (FRAME_SIZE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .transport_tcp  (tcp_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_frame_size (req_frame_size),
      .req_timestamp  (req_timestamp),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   h264rtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_entry  (head)
   );

   h264rtp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .transport_tcp    (tcp_ff),
      .stream_source_id (ssrc_ff),
      .head_valid       (head_valid),
      .head_pop         (head_pop),
      .head             (head),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

FILE: verif/h264_rtp_packetizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP packetizer testbench
// Streams Annex B frames into the block one byte per beat. An in-bench model
// predicts the RTP byte stream, covering single NAL unit packets, FU-A
// fragments and TCP interleaved framing. Every rsp beat is checked against
// that prediction while both channels idle and stall at random and the
// registers move through several settings.
// ----------------------------------------------------------------------------
module h264_rtp_packetizer_tb;

   localparam int unsigned TCP_LIMIT      = 1460;
   localparam int unsigned UDP_LIMIT      = 1472;
   localparam int unsigned RTP_HEADER_LEN = 12;
   localparam int unsigned TCP_HEADER_LEN = 16;
   localparam int unsigned FU_OVERHEAD    = 2;
   localparam int unsigned START_CODE_LEN = 4;
   localparam int unsigned NAL_HEADER_POS = 4;
   localparam int unsigned MIN_FRAME      = 5;

   localparam logic [7:0] INTERLEAVE_MAGIC   = 8'h24;
   localparam logic [7:0] INTERLEAVE_CHANNEL = 8'h00;
   localparam logic [7:0] RTP_V2             = 8'h80;
   localparam logic [6:0] PT_H264            = 7'd96;
   localparam logic [7:0] NRI_BITS           = 8'h60;
   localparam logic [7:0] TYPE_BITS          = 8'h1f;
   localparam logic [7:0] FU_A               = 8'd28;
   localparam logic [7:0] FU_S               = 8'h80;
   localparam logic [7:0] FU_E               = 8'h40;

   localparam int unsigned RANDOM_ITEMS = 250;
   localparam int unsigned DRAIN_CYCLES = 32;
   localparam int unsigned LONG_HOLD    = 300;
   localparam longint      TIMEOUT_NS   = 50_000_000;

   typedef struct {
      logic [7:0]  data;
      logic [19:0] size;
      logic [31:0] ts;
   } frame_beat_type;

   typedef struct {
      logic [7:0] data;
      logic       pkt_end;
      logic       frame_end;
   } rtp_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic [19:0] req_frame_size;
   logic [31:0] req_timestamp;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_packet_end;
   logic        rsp_frame_end;

   frame_beat_type staged[$];
   frame_beat_type req_pending[$];
   rtp_byte_type   expected_bytes[$];

   int unsigned beats_released = 0;
   int unsigned beats_accepted = 0;
   int unsigned mismatches     = 0;
   int unsigned tx_gap_left;
   int unsigned rx_stall_left;
   int unsigned rx_hold_left;
   logic        rx_hold_done;
   logic        idle_on = 1'b1;

   // Shadow of the packetizer state and its registers.
   logic        cfg_tcp    = 1'b1;
   logic [31:0] cfg_ssrc   = '0;
   logic [19:0] frame_pos  = '0;
   logic [15:0] seq_num    = '0;
   logic [7:0]  nal_header = '0;
   logic [10:0] frag_fill  = '0;
   logic        in_fu      = 1'b0;
   logic [31:0] frame_ts   = '0;

   h264_rtp_packetizer dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_frame_size (req_frame_size),
      .req_timestamp  (req_timestamp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_frame_end  (rsp_frame_end)
   );

   always #4 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 16);
   endfunction

   task automatic push_out(input logic [7:0] data, input logic pe, input logic fe);
      expected_bytes.push_back('{data, pe, fe});
   endtask

   task automatic push_rtp_header(input int unsigned body_len, input logic marker);
      logic [15:0]  tcp_len;
      logic [127:0] hdr_word;
      int           n;
      tcp_len  = 16'(body_len + RTP_HEADER_LEN);
      hdr_word = {INTERLEAVE_MAGIC, INTERLEAVE_CHANNEL, tcp_len, RTP_V2, marker, PT_H264,
                  seq_num, frame_ts, cfg_ssrc};
      n = cfg_tcp ? TCP_HEADER_LEN : RTP_HEADER_LEN;
      // The interleave prefix sits in the top four bytes and is skipped for UDP.
      for (int i = n - 1; i >= 0; i--)
         push_out(hdr_word[8*i +: 8], 1'b0, 1'b0);
   endtask

   task automatic predict_beat(input logic [7:0] data, input logic [19:0] size_field,
                               input logic [31:0] ts);
      int unsigned size, p, hdr_len, limit, frag_len, rem, fu_len;
      logic        last, end_frag, pe;
      size = size_field;
      if (size < MIN_FRAME)
         size = MIN_FRAME;
      p        = frame_pos;
      hdr_len  = cfg_tcp ? TCP_HEADER_LEN : RTP_HEADER_LEN;
      limit    = cfg_tcp ? TCP_LIMIT : UDP_LIMIT;
      frag_len = limit - hdr_len - FU_OVERHEAD;
      last     = (p + 1 >= size);
      if (p == 0)
         frame_ts = ts;
      if (p == NAL_HEADER_POS) begin
         nal_header = data;
         frag_fill  = '0;
         in_fu      = (size - START_CODE_LEN > limit - hdr_len);
         if (!in_fu) begin
            seq_num++;
            push_rtp_header(size - START_CODE_LEN, 1'b0);
            push_out(data, last, last);
         end
      end else if (p > NAL_HEADER_POS && !in_fu) begin
         push_out(data, last, last);
      end else if (p > NAL_HEADER_POS) begin
         if (frag_fill == 0) begin
            // A shrunken frame size can leave rem wrapped around, which
            // simply reads as a long fragment.
            rem      = size - p;
            end_frag = (rem <= frag_len);
            fu_len   = end_frag ? rem : frag_len;
            seq_num++;
            push_rtp_header(fu_len + FU_OVERHEAD, end_frag);
            push_out((nal_header & NRI_BITS) | FU_A, 1'b0, 1'b0);
            push_out(((p == NAL_HEADER_POS + 1) ? FU_S : 8'h00) |
                     (end_frag ? FU_E : 8'h00) | (nal_header & TYPE_BITS), 1'b0, 1'b0);
         end
         frag_fill++;
         pe = last || (frag_fill >= frag_len);
         if (pe)
            frag_fill = '0;
         push_out(data, pe, last);
      end
      if (last) begin
         frame_pos = '0;
         frag_fill = '0;
         in_fu     = 1'b0;
      end else begin
         frame_pos = 20'(p + 1);
      end
   endtask

   // A nonzero cut_at lowers the size field on that byte so the frame ends there.
   task automatic build_frame(input logic [19:0] size_field, input logic [31:0] ts,
                              input int unsigned cut_at);
      int unsigned    n_bytes;
      frame_beat_type beat;
      n_bytes = (size_field < MIN_FRAME) ? MIN_FRAME : size_field;
      if (cut_at != 0)
         n_bytes = cut_at + 1;
      for (int unsigned p = 0; p < n_bytes; p++) begin
         if (p < START_CODE_LEN - 1)
            beat.data = 8'h00;
         else if (p == START_CODE_LEN - 1)
            beat.data = 8'h01;
         else
            beat.data = 8'($urandom);
         beat.size = (cut_at != 0 && p == cut_at) ? 20'(cut_at + 1) : size_field;
         // Only the first byte's timestamp counts, so later ones may wander.
         beat.ts = (p == 0 || $urandom_range(0, 3) != 0) ? ts : $urandom;
         staged.push_back(beat);
      end
   endtask

   task automatic add_random_frame();
      int unsigned pick, cut;
      logic [31:0] ts;
      pick = $urandom_range(0, 99);
      ts   = $urandom;
      if (pick < 10) begin
         build_frame(20'($urandom_range(0, MIN_FRAME - 1)), ts, 0);
      end else if (pick < 30) begin
         cut = $urandom_range(NAL_HEADER_POS + 1, 30);
         if (pick < 20)
            build_frame(20'($urandom_range(cut + 2, 1500)), ts, cut);
         else
            build_frame(20'($urandom_range(1501, 20'hfffff)), ts, cut);
      end else begin
         build_frame(20'($urandom_range(MIN_FRAME, 40)), ts, 0);
      end
   endtask

   task automatic release_beats(input int unsigned n);
      if (n == 0)
         n = staged.size();
      repeat (n) req_pending.push_back(staged.pop_front());
      beats_released += n;
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (beats_accepted != beats_released || expected_bytes.size() != 0);
      // Start code beats leave nothing to wait for, so give the pipe time to settle.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic tcp_mode, input logic [31:0] ssrc);
      csr_index <= h264rtp_pkg::REG_TRANSPORT_TCP;
      csr_wdata <= {31'($urandom), tcp_mode};
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      cfg_tcp = tcp_mode;
      csr_index <= h264rtp_pkg::REG_SOURCE_ID;
      csr_wdata <= ssrc;
      do
         @(posedge clock);
      while (!csr_ready);
      cfg_ssrc = ssrc;
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: rsp %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : req_driver
      frame_beat_type beat;
      if (reset) begin
         req_valid   <= 1'b0;
         tx_gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_beat(req_data_byte, req_frame_size, req_timestamp);
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (tx_gap_left > 0) begin
               req_valid   <= 1'b0;
               tx_gap_left <= tx_gap_left - 1;
            end else if (req_pending.size() > 0) begin
               beat = req_pending.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= beat.data;
               req_frame_size <= beat.size;
               req_timestamp  <= beat.ts;
               tx_gap_left    <= idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rtp_byte_type want;
      if (reset) begin
         rsp_ready     <= 1'b0;
         rx_stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               $display("%0t: rsp beat expected none, got 0x%0h pe %0b fe %0b", $time,
                        rsp_out_byte, rsp_packet_end, rsp_frame_end);
            end else begin
               want = expected_bytes.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("packet_end", want.pkt_end, rsp_packet_end);
               check_field("frame_end", want.frame_end, rsp_frame_end);
            end
         end
         if (rx_hold_left > 0 || rx_stall_left > 0) begin
            rsp_ready <= 1'b0;
            if (rx_stall_left > 0)
               rx_stall_left <= rx_stall_left - 1;
         end else begin
            rsp_ready     <= 1'b1;
            rx_stall_left <= idle_on ? pick_gap() : 0;
         end
      end
   end

   // Long receiver hold-offs: one forced while the sender has plenty queued,
   // plus rare random ones.
   always @(posedge clock) begin : rx_hold_timer
      if (reset) begin
         rx_hold_left <= 0;
         rx_hold_done <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end else if (!rx_hold_done && req_pending.size() > 20) begin
         rx_hold_left <= LONG_HOLD;
         rx_hold_done <= 1'b1;
      end else if ($urandom_range(0, 2999) == 0) begin
         rx_hold_left <= $urandom_range(50, 200);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("h264_rtp_packetizer_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int unsigned counted;
      logic        tcp_mode;
      logic [31:0] ssrc;
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_index      = h264rtp_pkg::REG_TRANSPORT_TCP;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_frame_size = '0;
      req_timestamp  = '0;
      rsp_ready      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: TCP framing, zero source id. Minimum sizes, extreme
      // timestamps and frames whose size field drops mid-frame.
      build_frame(20'd5, 32'h0000_0000, 0);
      build_frame(20'd0, 32'hffff_ffff, 0);
      build_frame(20'd7, $urandom, 0);
      build_frame(20'hfffff, $urandom, 8);
      build_frame(20'd14, $urandom, 6);
      release_beats(0);
      wait_drained();

      // UDP with all-ones source id.
      configure(1'b0, 32'hffff_ffff);
      build_frame(20'd6, $urandom, 0);
      build_frame(20'hfffff, $urandom, 5);
      release_beats(0);
      wait_drained();

      // Switch from TCP to UDP in the middle of a fragmented frame.
      configure(1'b1, $urandom);
      idle_on = 1'b0;
      build_frame(20'($urandom_range(1500, 1800)), $urandom, 0);
      release_beats(100);
      wait_drained();
      configure(1'b0, cfg_ssrc);
      release_beats(0);
      wait_drained();

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         tcp_mode = $urandom_range(0, 1);
         case ($urandom_range(0, 3))
            0: ssrc = '0;
            1: ssrc = '1;
            default: ssrc = $urandom;
         endcase
         configure(tcp_mode, ssrc);
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (4) begin
            add_random_frame();
            counted += staged.size() - START_CODE_LEN;
            release_beats(0);
         end
         wait_drained();
      end

      if (mismatches == 0)
         $display("h264_rtp_packetizer_tb OK");
      else
         $display("h264_rtp_packetizer_tb NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/h264rtp_pkg.sv
rtl/core/h264rtp_front.sv
rtl/core/h264rtp_queue.sv
rtl/core/h264rtp_back.sv
rtl/core/h264_rtp_packetizer.sv
verif/h264_rtp_packetizer_tb.sv
